[hw/rtl/ltv_pkg.sv]
// Shared types and constants for the ledger transfer verifier.
package ltv_pkg;

  localparam int BAL_W = 32;
  localparam int SUM_W = 40;

  localparam logic [1:0] REG_SUPPLY    = 2'd0;
  localparam logic [1:0] REG_ACCOUNTS  = 2'd1;
  localparam logic [1:0] REG_TRANSFERS = 2'd2;

  typedef enum logic [3:0] {
    ST_VALID        = 4'd0,
    ST_NEG_INITIAL  = 4'd1,
    ST_INITIAL_SUM  = 4'd2,
    ST_BAD_SENDER   = 4'd3,
    ST_BAD_RECEIVER = 4'd4,
    ST_NONPOS_AMT   = 4'd5,
    ST_INSUFFICIENT = 4'd6,
    ST_NEG_AFTER    = 4'd7,
    ST_NEG_FINAL    = 4'd8,
    ST_MISMATCH     = 4'd9,
    ST_FINAL_SUM    = 4'd10,
    ST_OVERFLOW     = 4'd11
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic [30:0]               position;
    logic signed [BAL_W-1:0]   account;
    logic signed [SUM_W-1:0]   have_value;
    logic signed [BAL_W-1:0]   need_value;
  } verdict_t;

endpackage

[hw/rtl/ltv_bal_ram.sv]
// Balance table: one write port and one read port with registered read data.
module ltv_bal_ram import ltv_pkg::*; #(
  parameter int Depth = 256,
  localparam int AW = $clog2(Depth)
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [BAL_W-1:0] wdata,
  input  logic [AW-1:0]           raddr,
  output logic signed [BAL_W-1:0] rdata
);

  logic signed [BAL_W-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ledger_transfer_verifier_top.sv]
// Top level of the ledger transfer verifier: sequencer, checks and balance table.
//
// Usage: program total_supply, account_count and transfer_count through the
// cfg_write / cfg_index / cfg_data port while the block is idle. Then feed the
// beats of one ledger block on start/busy: account_count initial balances,
// transfer_count transfers (sender, receiver, value), account_count claimed
// final balances. A beat is taken when start is high and busy is low.
// The verdict appears for one cycle with done high: at the first failing beat,
// or with status zero at the last beat of a clean block. Later beats of a
// failed block are taken and dropped.
// A clean initial balance beat is written on acceptance, a final balance beat is
// read back in S_FINAL, and a transfer beat runs sender read, receiver read,
// check with sender write-back, and receiver write-back, all through the single
// read and single write port of the balance table. A bad index or amount, or a
// failed block's beat, raises no busy; failed balance checks end at S_CHECK.
// done is high in the cycle after the edge that decides the verdict: the
// accepting edge for initial balances and index or amount checks, the edge
// that ends the last busy cycle for balance checks and final claims.
// Reset clears the sequencer and restores the register reset values; the
// balance table needs no clearing. The receiver cannot stall done.
module ledger_transfer_verifier_top import ltv_pkg::*; #(
  parameter int ACCT_SLOTS = 256
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      sender,
  input  logic signed [31:0]      receiver,
  input  logic signed [31:0]      value,
  input  logic                    cfg_write,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output logic                    done,
  output logic [3:0]              status,
  output logic [30:0]             position,
  output logic signed [31:0]      account,
  output logic signed [39:0]      have_value,
  output logic signed [31:0]      need_value
);

  localparam int IW = $clog2(ACCT_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_RECV,
    S_CHECK,
    S_WR_RECV,
    S_FINAL
  } state_t;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_XFER,
    PH_FINAL
  } phase_t;

  state_t state;
  phase_t phase;

  logic signed [31:0]      total_supply;
  logic [8:0]              account_count;
  logic [30:0]             transfer_count;
  logic signed [31:0]      blk_supply;
  logic [8:0]              blk_accounts;
  logic [30:0]             blk_transfers;

  logic [30:0]             cnt;
  logic signed [SUM_W-1:0] sum;
  logic                    failed;

  logic [30:0]             k_q;
  logic signed [31:0]      s_q;
  logic signed [31:0]      r_q;
  logic signed [31:0]      v_q;
  logic                    last_q;
  logic signed [31:0]      bs_q;
  logic signed [31:0]      nr_q;

  verdict_t                res;

  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic signed [31:0]      mem_wdata;
  logic [IW-1:0]           mem_raddr;
  logic signed [31:0]      mem_rdata;

  logic                    accept;
  logic                    first;
  logic [8:0]              cfg_accounts;
  logic [8:0]              eff_accounts;
  logic [30:0]             eff_transfers;
  logic signed [31:0]      eff_supply;
  logic                    eff_failed;
  logic signed [SUM_W-1:0] eff_sum;
  logic signed [SUM_W-1:0] sum_init;
  logic signed [SUM_W-1:0] sum_fin;
  logic signed [SUM_W-1:0] supply_ext;
  logic                    last_acct;
  logic                    last_xfer;
  logic                    val_neg;
  logic                    s_bad;
  logic                    r_bad;
  logic                    amt_bad;
  logic                    insuff;
  logic signed [32:0]      ns;
  logic signed [33:0]      nr;
  logic                    ovf;
  logic                    neg_after;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign first  = (phase == PH_INIT) && (cnt == '0);

  always_comb begin
    if (account_count == 9'd0) begin
      cfg_accounts = 9'd1;
    end else if (32'(account_count) > 32'(ACCT_SLOTS)) begin
      cfg_accounts = 9'(ACCT_SLOTS);
    end else begin
      cfg_accounts = account_count;
    end
  end

  assign eff_accounts  = first ? cfg_accounts : blk_accounts;
  assign eff_transfers = first ? transfer_count : blk_transfers;
  assign eff_supply    = first ? total_supply : blk_supply;
  assign eff_failed    = first ? 1'b0 : failed;
  assign eff_sum       = first ? '0 : sum;
  assign supply_ext    = SUM_W'(eff_supply);

  assign val_neg   = value[31];
  assign sum_init  = eff_sum + SUM_W'(value);
  assign last_acct = ({1'b0, cnt} + 32'd1) >= {23'd0, eff_accounts};
  assign last_xfer = ({1'b0, cnt} + 32'd1) >= {1'b0, blk_transfers};

  assign s_bad   = sender[31] || (sender[30:0] >= {22'd0, blk_accounts});
  assign r_bad   = receiver[31] || (receiver[30:0] >= {22'd0, blk_accounts});
  assign amt_bad = value[31] || (value == 32'sd0);

  assign insuff    = bs_q < v_q;
  assign ns        = 33'(bs_q) - 33'(v_q);
  assign nr        = ((r_q == s_q) ? 34'(ns) : 34'(mem_rdata)) + 34'(v_q);
  assign ovf       = nr > 34'sd2147483647;
  assign neg_after = (r_q != s_q) && ns[32];

  assign sum_fin = sum + SUM_W'(mem_rdata);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt[IW-1:0];
    mem_wdata = value;
    mem_raddr = cnt[IW-1:0];
    unique case (state)
      S_IDLE: begin
        if (accept && phase == PH_INIT) begin
          mem_we = !eff_failed && !val_neg;
        end
        if (phase == PH_XFER) begin
          mem_raddr = sender[IW-1:0];
        end
      end
      S_RD_RECV: begin
        mem_raddr = r_q[IW-1:0];
      end
      S_CHECK: begin
        mem_we    = !insuff && !ovf && !neg_after;
        mem_waddr = s_q[IW-1:0];
        mem_wdata = ns[31:0];
      end
      S_WR_RECV: begin
        mem_we    = 1'b1;
        mem_waddr = r_q[IW-1:0];
        mem_wdata = nr_q;
      end
      S_FINAL: begin
        mem_raddr = cnt[IW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  ltv_bal_ram #(
    .Depth(ACCT_SLOTS)
  ) u_bal_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase          <= PH_INIT;
      cnt            <= '0;
      sum            <= '0;
      failed         <= 1'b0;
      total_supply   <= '0;
      account_count  <= 9'd1;
      transfer_count <= '0;
      blk_supply     <= '0;
      blk_accounts   <= 9'd1;
      blk_transfers  <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SUPPLY:    total_supply   <= cfg_data;
          REG_ACCOUNTS:  account_count  <= cfg_data[8:0];
          REG_TRANSFERS: transfer_count <= cfg_data[30:0];
          default: begin
          end
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            k_q <= cnt;
            s_q <= sender;
            r_q <= receiver;
            v_q <= value;
            if (first) begin
              blk_accounts  <= cfg_accounts;
              blk_transfers <= transfer_count;
              blk_supply    <= total_supply;
            end
            unique case (phase)
              PH_INIT: begin
                failed <= eff_failed || val_neg || (last_acct && sum_init != supply_ext);
                if (!eff_failed && val_neg) begin
                  res  <= '{ST_NEG_INITIAL, cnt, {1'b0, cnt}, SUM_W'(value), '0};
                  done <= 1'b1;
                end else if (!eff_failed && last_acct && sum_init != supply_ext) begin
                  res  <= '{ST_INITIAL_SUM, cnt, '0, sum_init, eff_supply};
                  done <= 1'b1;
                end
                if (last_acct) begin
                  sum   <= '0;
                  cnt   <= '0;
                  phase <= (eff_transfers == '0) ? PH_FINAL : PH_XFER;
                end else begin
                  sum <= sum_init;
                  cnt <= cnt + 31'd1;
                end
              end
              PH_XFER: begin
                if (!failed) begin
                  if (s_bad) begin
                    res    <= '{ST_BAD_SENDER, cnt, sender, '0, '0};
                    done   <= 1'b1;
                    failed <= 1'b1;
                  end else if (r_bad) begin
                    res    <= '{ST_BAD_RECEIVER, cnt, receiver, '0, '0};
                    done   <= 1'b1;
                    failed <= 1'b1;
                  end else if (amt_bad) begin
                    res    <= '{ST_NONPOS_AMT, cnt, '0, '0, value};
                    done   <= 1'b1;
                    failed <= 1'b1;
                  end else begin
                    state <= S_RD_RECV;
                  end
                end
                if (last_xfer) begin
                  cnt   <= '0;
                  phase <= PH_FINAL;
                end else begin
                  cnt <= cnt + 31'd1;
                end
              end
              PH_FINAL: begin
                last_q <= last_acct;
                if (!failed) begin
                  state <= S_FINAL;
                end
                if (last_acct) begin
                  cnt   <= '0;
                  phase <= PH_INIT;
                end else begin
                  cnt <= cnt + 31'd1;
                end
              end
              default: begin
                phase <= PH_INIT;
              end
            endcase
          end
        end
        S_RD_RECV: begin
          bs_q  <= mem_rdata;
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_IDLE;
          if (insuff) begin
            res    <= '{ST_INSUFFICIENT, k_q, s_q, SUM_W'(bs_q), v_q};
            done   <= 1'b1;
            failed <= 1'b1;
          end else if (ovf) begin
            res    <= '{ST_OVERFLOW, k_q, r_q, SUM_W'(nr), v_q};
            done   <= 1'b1;
            failed <= 1'b1;
          end else if (neg_after) begin
            res    <= '{ST_NEG_AFTER, k_q, s_q, SUM_W'(ns), '0};
            done   <= 1'b1;
            failed <= 1'b1;
          end else begin
            nr_q  <= nr[31:0];
            state <= S_WR_RECV;
          end
        end
        S_WR_RECV: begin
          state <= S_IDLE;
        end
        S_FINAL: begin
          state <= S_IDLE;
          if (mem_rdata[31]) begin
            res    <= '{ST_NEG_FINAL, k_q, {1'b0, k_q}, SUM_W'(mem_rdata), '0};
            done   <= 1'b1;
            failed <= 1'b1;
          end else if (mem_rdata != v_q) begin
            res    <= '{ST_MISMATCH, k_q, {1'b0, k_q}, SUM_W'(mem_rdata), v_q};
            done   <= 1'b1;
            failed <= 1'b1;
          end else begin
            sum <= sum_fin;
            if (last_q) begin
              done <= 1'b1;
              if (sum_fin != SUM_W'(blk_supply)) begin
                res <= '{ST_FINAL_SUM, k_q, '0, sum_fin, blk_supply};
              end else begin
                res <= '{ST_VALID, blk_transfers, '0, sum_fin, blk_supply};
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign status     = res.status;
  assign position   = res.position;
  assign account    = res.account;
  assign have_value = res.have_value;
  assign need_value = res.need_value;

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept) || $past(busy))
    else $error("verdict without a beat in progress");

  a_valid_balanced: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_VALID) |-> have_value == SUM_W'(need_value))
    else $error("clean verdict with unbalanced sum");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_IDLE) |-> (accept && phase == PH_INIT))
    else $error("table write outside the initial balance phase");

  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    busy ##1 busy ##1 busy |=> !busy)
    else $error("beat held busy too long");

endmodule
